// ===== src/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

   localparam int REQ_W       = 16;
   localparam int HDR_W       = 7;
   localparam int ADDR_W      = 15;
   localparam int USER_W      = 16;
   localparam int ORDER_W     = 4;
   // internal order width, wide enough for the largest top order (16)
   localparam int ORD_IW      = 5;
   localparam int TOTAL_W     = REQ_W + 1;

   localparam logic [HDR_W-1:0] HEADER_RESET = 7'd24;

   typedef enum logic [1:0] {
      STATUS_GRANTED   = 2'd0,
      STATUS_ZERO      = 2'd1,
      STATUS_TOO_LARGE = 2'd2,
      STATUS_NO_ARENA  = 2'd3
   } status_type;

   typedef struct packed {
      logic              zero;
      logic              too_large;
      logic [ORD_IW-1:0] want;
   } decode_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] block_address;
      logic [ORD_IW-1:0] block_order;
   } grant_type;

endpackage
`default_nettype wire

// ===== src/bba_req_if.sv =====
`default_nettype none
interface bba_req_if;
   logic                       valid;
   logic                       ready;
   logic [bba_pkg::REQ_W-1:0]  request_bytes;

   modport source (output valid, output request_bytes, input ready);
   modport sink   (input valid, input request_bytes, output ready);
endinterface
`default_nettype wire

// ===== src/bba_rsp_if.sv =====
`default_nettype none
interface bba_rsp_if;
   logic                        valid;
   logic                        ready;
   bba_pkg::status_type         status;
   logic [bba_pkg::ADDR_W-1:0]  block_address;
   logic [bba_pkg::USER_W-1:0]  user_address;
   logic [bba_pkg::ORDER_W-1:0] block_order;

   modport source (output valid, output status, output block_address,
                   output user_address, output block_order, input ready);
   modport sink   (input valid, input status, input block_address,
                   input user_address, input block_order, output ready);
endinterface
`default_nettype wire

// ===== src/bba_csr_if.sv =====
`default_nettype none
interface bba_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bba_pkg::HDR_W-1:0]  header_bytes;

   modport source (output valid, output header_bytes, input ready);
   modport sink   (input valid, input header_bytes, output ready);
endinterface
`default_nettype wire

// ===== src/bba_size_decode.sv =====
`default_nettype none
module bba_size_decode #(
   parameter int MIN_BLOCK_BYTES = 8,
   parameter int TOP_ORDER       = 8
) (
   input  wire logic [bba_pkg::REQ_W-1:0] request_bytes,
   input  wire logic [bba_pkg::HDR_W-1:0] header_bytes,
   output bba_pkg::decode_type            decode
);

   localparam int ARENA_BYTES = MIN_BLOCK_BYTES << TOP_ORDER;

   logic [bba_pkg::TOTAL_W-1:0] total;

   assign total = bba_pkg::TOTAL_W'(request_bytes) + bba_pkg::TOTAL_W'(header_bytes);

   always_comb begin
      decode.zero      = (request_bytes == '0);
      decode.too_large = (32'(total) > 32'(ARENA_BYTES));
      // smallest order whose block holds the total
      decode.want = bba_pkg::ORD_IW'(TOP_ORDER);
      for (int o = TOP_ORDER - 1; o >= 0; o--) begin
         if (32'(total) <= 32'(MIN_BLOCK_BYTES << o)) begin
            decode.want = bba_pkg::ORD_IW'(o);
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/bba_free_table.sv =====
`default_nettype none
module bba_free_table #(
   parameter int MIN_BLOCK_BYTES = 8,
   parameter int TOP_ORDER       = 8,
   parameter int ARENA_LIMIT     = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire bba_pkg::decode_type decode,
   output bba_pkg::grant_type      grant
);

   localparam int ORDERS      = TOP_ORDER + 1;
   localparam int OW          = $clog2(ORDERS);
   localparam int AW          = $clog2(ARENA_LIMIT + 1);
   localparam int ARENA_BYTES = MIN_BLOCK_BYTES << TOP_ORDER;

   logic [ORDERS-1:0]                valid_ff, valid_in;
   logic [bba_pkg::ADDR_W-1:0]       addr_ff [ORDERS];
   logic [AW-1:0]                    arenas_ff, arenas_in;
   logic [bba_pkg::ADDR_W-1:0]       arena_addr_ff, arena_addr_in;

   logic [ORDERS-1:0]                avail;
   logic [OW-1:0]                    found;
   logic                             hit;
   logic                             full;
   logic                             granted;
   logic [bba_pkg::ADDR_W-1:0]       base;
   logic [bba_pkg::ORD_IW-1:0]       top_ord;
   logic [ORDERS-1:0]                split;

   always_comb begin
      for (int k = 0; k < ORDERS; k++) begin
         avail[k] = valid_ff[k] && (bba_pkg::ORD_IW'(k) >= decode.want);
      end
      // lowest free order at or above the wanted one
      found = '0;
      hit   = 1'b0;
      for (int k = ORDERS - 1; k >= 0; k--) begin
         if (avail[k]) begin
            found = OW'(k);
            hit   = 1'b1;
         end
      end
   end

   assign full    = (32'(arenas_ff) >= 32'(ARENA_LIMIT));
   assign base    = hit ? addr_ff[found] : arena_addr_ff;
   assign top_ord = hit ? bba_pkg::ORD_IW'(found) : bba_pkg::ORD_IW'(TOP_ORDER);
   assign granted = !decode.zero && !decode.too_large && (hit || !full);

   always_comb begin
      grant.block_address = '0;
      grant.block_order   = '0;
      priority if (decode.zero) begin
         grant.status = bba_pkg::STATUS_ZERO;
      end else if (decode.too_large) begin
         grant.status = bba_pkg::STATUS_TOO_LARGE;
      end else if (!hit && full) begin
         grant.status = bba_pkg::STATUS_NO_ARENA;
      end else begin
         grant.status        = bba_pkg::STATUS_GRANTED;
         grant.block_address = base;
         grant.block_order   = decode.want;
      end
   end

   // orders that receive an upper buddy when the block is split down
   always_comb begin
      for (int k = 0; k < ORDERS; k++) begin
         split[k] = (bba_pkg::ORD_IW'(k) >= decode.want) && (bba_pkg::ORD_IW'(k) < top_ord);
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      arenas_in     = arenas_ff;
      arena_addr_in = arena_addr_ff;
      if (fire && granted) begin
         if (hit) begin
            valid_in[found] = 1'b0;
         end else begin
            arenas_in     = arenas_ff + AW'(1);
            arena_addr_in = arena_addr_ff + bba_pkg::ADDR_W'(ARENA_BYTES);
         end
         valid_in = valid_in | split;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         arenas_ff     <= '0;
         arena_addr_ff <= '0;
      end else begin
         valid_ff      <= valid_in;
         arenas_ff     <= arenas_in;
         arena_addr_ff <= arena_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ORDERS; k++) begin
         if (fire && granted && split[k]) begin
            addr_ff[k] <= base + bba_pkg::ADDR_W'(MIN_BLOCK_BYTES << k);
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/buddy_block_allocator_top.sv =====
// Buddy block allocator, allocation only.
// req_in carries one word per request: a payload size in bytes. rsp_out returns
// one word per request: status, block address, user address and block order.
// csr_wr writes the header size; it is always ready and may be written only
// while no request is in flight.
// A request accepted on req_in passes through an input register holding the
// decoded size, then the response register, before it shows on rsp_out.
// Throughput: one request per cycle while rsp_out is ready; the free-order search,
// split and state update for one request fit in the cycle between those
// two registers, so the next request sees the updated free table.
// When the receiver stalls, the response holds and one more request waits
// in the input register; req_in.ready drops only when both are full.
// Reset clears the free table, the arena count and both valid flags and
// sets the header size to 24 bytes.
`default_nettype none
module buddy_block_allocator_top #(
   parameter int MIN_BLOCK_BYTES = 8,
   parameter int TOP_ORDER       = 8,
   parameter int ARENA_LIMIT     = 16
) (
   input wire logic clock,
   input wire logic reset,
   bba_req_if.sink   req_in,
   bba_rsp_if.source rsp_out,
   bba_csr_if.sink   csr_wr
);

   logic [bba_pkg::HDR_W-1:0]   header_ff, header_in;
   logic                        s1_valid_ff, s1_valid_in;
   bba_pkg::decode_type         s1_dec_ff, s1_dec_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   bba_pkg::grant_type          rsp_ff, rsp_in;
   logic [bba_pkg::USER_W-1:0]  user_ff, user_in;
   logic                        advance;
   logic                        take;
   bba_pkg::decode_type         dec;
   bba_pkg::grant_type          grant;

   assign csr_wr.ready = 1'b1;
   assign header_in    = (csr_wr.valid) ? csr_wr.header_bytes : header_ff;

   bba_size_decode #(
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
      .TOP_ORDER       (TOP_ORDER)
   ) u_decode (
      .request_bytes (req_in.request_bytes),
      .header_bytes  (header_ff),
      .decode        (dec)
   );

   bba_free_table #(
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
      .TOP_ORDER       (TOP_ORDER),
      .ARENA_LIMIT     (ARENA_LIMIT)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .decode (s1_dec_ff),
      .grant  (grant)
   );

   // advance the input word into the response register when it is empty or its word is being taken
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_out.ready);
   assign req_in.ready = !s1_valid_ff || advance;
   assign take         = req_in.valid && req_in.ready;

   assign s1_valid_in  = take || (s1_valid_ff && !advance);
   assign s1_dec_in    = take ? dec : s1_dec_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_out.ready);
   assign rsp_in       = advance ? grant : rsp_ff;

   always_comb begin
      user_in = user_ff;
      if (advance) begin
         user_in = '0;
         if (grant.status == bba_pkg::STATUS_GRANTED) begin
            user_in = bba_pkg::USER_W'(grant.block_address)
                    + bba_pkg::USER_W'(header_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= bba_pkg::HEADER_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         header_ff    <= header_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dec_ff <= s1_dec_in;
      rsp_ff    <= rsp_in;
      user_ff   <= user_in;
   end

   assign rsp_out.valid         = rsp_valid_ff;
   assign rsp_out.status        = rsp_ff.status;
   assign rsp_out.block_address = rsp_ff.block_address;
   assign rsp_out.user_address  = user_ff;
   assign rsp_out.block_order   = bba_pkg::ORDER_W'(rsp_ff.block_order);

endmodule
`default_nettype wire

// ===== verif/buddy_block_allocator_top_tb.sv =====
`default_nettype none
module buddy_block_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLOCK_UNIT  = 8;
   localparam int TOP_ORDER   = 8;
   localparam int ARENA_LIMIT = 16;
   localparam int ARENA_BYTES = BLOCK_UNIT << TOP_ORDER;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      bba_pkg::status_type          status;
      logic [bba_pkg::ADDR_W-1:0]   block_address;
      logic [bba_pkg::USER_W-1:0]   user_address;
      logic [bba_pkg::ORDER_W-1:0]  block_order;
   } grant_word_type;

   logic clock;
   logic reset;

   bba_req_if req_if();
   bba_rsp_if rsp_if();
   bba_csr_if csr_if();

   buddy_block_allocator_top #(
      .MIN_BLOCK_BYTES (BLOCK_UNIT),
      .TOP_ORDER       (TOP_ORDER),
      .ARENA_LIMIT     (ARENA_LIMIT)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_if),
      .rsp_out (rsp_if),
      .csr_wr  (csr_if)
   );

   // allocator shadow state
   logic [bba_pkg::HDR_W-1:0]  header_cfg;
   bit                         free_valid [0:TOP_ORDER];
   logic [bba_pkg::ADDR_W-1:0] free_addr  [0:TOP_ORDER];
   int                         arenas_opened;

   logic [bba_pkg::REQ_W-1:0]  pending_requests [$];
   grant_word_type             expected_grants  [$];

   int error_count;
   bit req_taken;
   int req_gap_left;
   int req_calm_left;
   int rsp_stall_left;
   int rsp_calm_left;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic grant_word_type predict_grant(
      input logic [bba_pkg::REQ_W-1:0] req_bytes);
      grant_word_type res;
      int             total;
      int             want;
      int             found;
      int             base;
      bit             hit;
      res = '0;
      res.status = bba_pkg::STATUS_GRANTED;
      total = int'(req_bytes) + int'(header_cfg);
      if (req_bytes == '0) begin
         res.status = bba_pkg::STATUS_ZERO;
         return res;
      end
      if (total > ARENA_BYTES) begin
         res.status = bba_pkg::STATUS_TOO_LARGE;
         return res;
      end
      want = 0;
      while (want < TOP_ORDER && (BLOCK_UNIT << want) < total) want++;
      hit = 1'b0;
      found = want;
      for (int j = want; j <= TOP_ORDER; j++) begin
         if (!hit && free_valid[j]) begin
            found = j;
            hit = 1'b1;
         end
      end
      if (hit) begin
         base = int'(free_addr[found]);
         free_valid[found] = 1'b0;
      end else if (arenas_opened >= ARENA_LIMIT) begin
         res.status = bba_pkg::STATUS_NO_ARENA;
         return res;
      end else begin
         base = (arenas_opened * ARENA_BYTES) & ((1 << bba_pkg::ADDR_W) - 1);
         arenas_opened++;
         found = TOP_ORDER;
      end
      // split down, leave each upper buddy on its free list
      while (found > want) begin
         found--;
         free_valid[found] = 1'b1;
         free_addr[found]  = bba_pkg::ADDR_W'(base + (BLOCK_UNIT << found));
      end
      res.block_address = bba_pkg::ADDR_W'(base);
      res.user_address  = bba_pkg::USER_W'(base + int'(header_cfg));
      res.block_order   = bba_pkg::ORDER_W'(want);
      return res;
   endfunction

   function automatic int pick_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 2) begin
         calm_left = $urandom_range(60, 20);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [bba_pkg::REQ_W-1:0] pick_request_bytes();
      int roll;
      int size;
      int ord;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 10) return bba_pkg::REQ_W'($urandom_range(65535));
      if (roll < 24) begin
         // land on, just below or just above a block size boundary
         ord = ($urandom_range(99) == 0) ? TOP_ORDER : $urandom_range(4);
         size = (BLOCK_UNIT << ord) - int'(header_cfg) + $urandom_range(2) - 1;
         return bba_pkg::REQ_W'((size < 1) ? 1 : size);
      end
      if (roll < 32) return bba_pkg::REQ_W'($urandom_range(400, 49));
      if (roll < 33) return bba_pkg::REQ_W'($urandom_range(ARENA_BYTES, 401));
      return bba_pkg::REQ_W'($urandom_range(24, 1));
   endfunction

   // request side: hold each word until taken, then idle a while
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_if.valid && req_if.ready) begin
         req_taken = 1'b1;
         expected_grants.push_back(predict_grant(req_if.request_bytes));
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_if.valid         <= 1'b1;
            req_if.request_bytes <= pending_requests.pop_front();
            req_gap_left = pick_gap(req_calm_left);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_stall_left = pick_gap(rsp_calm_left);
      end
   end

   always @(posedge clock) begin
      grant_word_type got;
      grant_word_type exp_word;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status        = rsp_if.status;
         got.block_address = rsp_if.block_address;
         got.user_address  = rsp_if.user_address;
         got.block_order   = rsp_if.block_order;
         if (expected_grants.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("%0t: unexpected response word: status %s block %0d user %0d order %0d",
                        $realtime, got.status.name(), got.block_address, got.user_address,
                        got.block_order);
            error_count++;
         end else begin
            exp_word = expected_grants.pop_front();
            if (got.status !== exp_word.status ||
                got.block_address !== exp_word.block_address ||
                got.user_address !== exp_word.user_address ||
                got.block_order !== exp_word.block_order) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t: mismatch: expected %s/%0d/%0d/%0d got %s/%0d/%0d/%0d",
                           $realtime, exp_word.status.name(), exp_word.block_address,
                           exp_word.user_address, exp_word.block_order, got.status.name(),
                           got.block_address, got.user_address, got.block_order);
               error_count++;
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_if.valid || expected_grants.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_header(input logic [bba_pkg::HDR_W-1:0] value);
      @(negedge clock);
      csr_if.valid        <= 1'b1;
      csr_if.header_bytes <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      header_cfg = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      logic [bba_pkg::REQ_W-1:0] directed [$];
      int                        phase_header [6];
      int                        phase_items  [6];
      req_if.valid         = 1'b0;
      req_if.request_bytes = '0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.header_bytes  = '0;
      reset                = 1'b1;
      error_count          = 0;
      req_taken            = 1'b0;
      req_gap_left         = 0;
      req_calm_left        = 0;
      rsp_stall_left       = 0;
      rsp_calm_left        = 0;
      header_cfg           = bba_pkg::HEADER_RESET;
      arenas_opened        = 0;
      for (int i = 0; i <= TOP_ORDER; i++) begin
         free_valid[i] = 1'b0;
         free_addr[i]  = '0;
      end
      phase_header = '{0, 127, 64, 1, $urandom_range(127), 24};
      phase_items  = '{200, 20, 60, 200, 100, 180};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset header: zero size, orders 2 to the top, exact top fit, just over, widest values
      directed = '{16'd0, 16'd1, 16'd8, 16'd40, 16'd104, 16'd232, 16'd488, 16'd1000,
                   16'd2024, 16'd2025, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd1, 16'd1, 16'd9};
      foreach (directed[i]) pending_requests.push_back(directed[i]);

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_header(bba_pkg::HDR_W'(phase_header[p]));
         // with no header, hit the smallest orders first
         if (phase_header[p] == 0) begin
            pending_requests.push_back(bba_pkg::REQ_W'(8));
            pending_requests.push_back(bba_pkg::REQ_W'(9));
            pending_requests.push_back(bba_pkg::REQ_W'(16));
            pending_requests.push_back(bba_pkg::REQ_W'(17));
         end
         for (int i = 0; i < phase_items[p]; i++)
            pending_requests.push_back(pick_request_bytes());
      end
      // drain whatever arenas remain
      for (int i = 0; i < 20; i++)
         pending_requests.push_back(bba_pkg::REQ_W'(ARENA_BYTES - int'(header_cfg)));

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
